@@ rtl/nst_pkg.sv @@
`default_nettype none

package nst_pkg;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int TIME_W  = 40;
  localparam int PITCH_W = 7;
  localparam int GRID_W  = 26;
  localparam int AMT_W   = 9;
  localparam int DELAY_W = 25;

  // Held-note storage geometry
  localparam int PITCH_COUNT = 128;
  localparam int HELD_DEPTH  = 4;
  localparam int PIDX_W      = (PITCH_COUNT > 1) ? $clog2(PITCH_COUNT) : 1;
  localparam int SLOT_W      = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int CNT_W       = $clog2(HELD_DEPTH + 1);
  localparam int STORE_DEPTH = PITCH_COUNT * HELD_DEPTH;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Swing delay = amount * grid / 768, done as >> 8 then serial / 3
  localparam int AMT_FULL    = 256;
  localparam int PROD_W      = AMT_W + GRID_W;
  localparam int FRAC_SHIFT  = 8;
  localparam int DIVISOR3    = 3;

  // Serial unit step counts
  localparam int DIV_STEPS   = TIME_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int DIV3_STEPS  = GRID_W;
  localparam int DIV3_CNT_W  = $clog2(DIV3_STEPS);

  // Event kinds
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_ON  = 2'd0;
  localparam mode_t MODE_OFF = 2'd1;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_GRID  = 1'b0;
  localparam logic REG_SWING = 1'b1;
  localparam logic [GRID_W-1:0] GRID_RESET  = 26'd250000;
  localparam logic [AMT_W-1:0]  SWING_RESET = 9'd128;

  // Held-note FIFO command and status
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [DELAY_W-1:0] delay;
  } fifo_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

@@ rtl/nst_if.sv @@
`default_nettype none

// Input item channel
interface nst_in_if;
  logic                         valid;
  logic                         ready;
  logic [nst_pkg::MODE_W-1:0]   mode;
  logic [nst_pkg::TIME_W-1:0]   event_time;
  logic [nst_pkg::PITCH_W-1:0]  pitch;
  logic                         held;

  modport source (output valid, mode, event_time, pitch, held, input ready);
  modport sink   (input valid, mode, event_time, pitch, held, output ready);
endinterface

// Result item channel
interface nst_out_if;
  logic                         valid;
  logic                         ready;
  logic [nst_pkg::MODE_W-1:0]   out_mode;
  logic [nst_pkg::TIME_W-1:0]   out_time;
  logic [nst_pkg::PITCH_W-1:0]  out_pitch;
  logic                         fifo_dropped;

  modport source (output valid, out_mode, out_time, out_pitch, fifo_dropped, input ready);
  modport sink   (input valid, out_mode, out_time, out_pitch, fifo_dropped, output ready);
endinterface

`default_nettype wire

@@ rtl/nst_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// Keeps only the remainder and the parity of the quotient.
module nst_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [nst_pkg::TIME_W-1:0]  dividend,
  input  wire logic [nst_pkg::GRID_W-1:0]  divisor,
  output logic      [nst_pkg::GRID_W-1:0]  rem,
  output logic                             q_odd,
  output logic                             done
);

  logic [nst_pkg::TIME_W-1:0]    dvd_r;
  logic [nst_pkg::GRID_W-1:0]    rem_r, rem_nxt;
  logic                          q_odd_r;
  logic [nst_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;
  logic [nst_pkg::GRID_W:0]      trial, diff;
  logic                          ge;

  // One trial subtraction
  always_comb begin
    trial   = {rem_r, dvd_r[nst_pkg::TIME_W-1]};
    ge      = trial >= {1'b0, divisor};
    diff    = trial - {1'b0, divisor};
    rem_nxt = ge ? diff[nst_pkg::GRID_W-1:0] : trial[nst_pkg::GRID_W-1:0];
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == nst_pkg::DIV_CNT_W'(nst_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r   <= {dvd_r[nst_pkg::TIME_W-2:0], 1'b0};
      rem_r   <= rem_nxt;
      q_odd_r <= ge;
    end
  end

  assign rem   = rem_r;
  assign q_odd = q_odd_r;
  assign done  = done_r;

endmodule

`default_nettype wire

@@ rtl/nst_div3.sv @@
`default_nettype none

// Serial divide by three, one bit per cycle with a two-bit remainder.
module nst_div3 (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [nst_pkg::GRID_W-1:0]   value,
  output logic      [nst_pkg::DELAY_W-1:0]  quo
);

  logic [nst_pkg::GRID_W-1:0]     sh_r;
  logic [1:0]                     rem_r, rem_nxt;
  logic [nst_pkg::DELAY_W-1:0]    quo_r;
  logic [nst_pkg::DIV3_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic [2:0]                     x, xd;
  logic                           ge;

  // One digit step
  always_comb begin
    x       = {rem_r, sh_r[nst_pkg::GRID_W-1]};
    ge      = x >= 3'(nst_pkg::DIVISOR3);
    xd      = x - 3'(nst_pkg::DIVISOR3);
    rem_nxt = ge ? xd[1:0] : x[1:0];
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == nst_pkg::DIV3_CNT_W'(nst_pkg::DIV3_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Quotient shifts in at the LSB, MSB first; top bit of a 26-bit / 3 is always zero
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= value;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[nst_pkg::GRID_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[nst_pkg::DELAY_W-2:0], ge};
    end
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

@@ rtl/nst_fifo.sv @@
`default_nettype none

// Per-pitch FIFOs of held-note delays: head/count memory with valid bits,
// and the delay store addressed as pitch * depth + slot.
module nst_fifo (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [nst_pkg::PIDX_W-1:0]   pitch,
  input  wire nst_pkg::fifo_cmd_t           cmd,
  output nst_pkg::fifo_stat_t               stat,
  output logic      [nst_pkg::DELAY_W-1:0]  pop_delay
);

  logic [nst_pkg::SLOT_W-1:0]  head_mem [nst_pkg::PITCH_COUNT];
  logic [nst_pkg::CNT_W-1:0]   cnt_mem  [nst_pkg::PITCH_COUNT];
  logic [nst_pkg::DELAY_W-1:0] dly_mem  [nst_pkg::STORE_DEPTH];
  logic [nst_pkg::PITCH_COUNT-1:0] vld_r;

  logic [nst_pkg::SLOT_W-1:0]  head_rd_r, head, head_inc, slot;
  logic [nst_pkg::CNT_W-1:0]   cnt_rd_r, count;
  logic                        vld_rd_r;
  logic [nst_pkg::CNT_W:0]     sum;
  logic [nst_pkg::ADDR_W-1:0]  waddr, raddr, base;
  logic [nst_pkg::DELAY_W-1:0] pop_rd_r;

  // Entries never written read as an empty FIFO
  always_comb begin
    head  = vld_rd_r ? head_rd_r : '0;
    count = vld_rd_r ? cnt_rd_r : '0;
    stat.full  = count >= nst_pkg::CNT_W'(nst_pkg::HELD_DEPTH);
    stat.empty = count == '0;
    // tail slot, wrapped
    sum = (nst_pkg::CNT_W+1)'(head) + (nst_pkg::CNT_W+1)'(count);
    if (sum >= (nst_pkg::CNT_W+1)'(nst_pkg::HELD_DEPTH)) begin
      slot = nst_pkg::SLOT_W'(sum - (nst_pkg::CNT_W+1)'(nst_pkg::HELD_DEPTH));
    end else begin
      slot = nst_pkg::SLOT_W'(sum);
    end
    head_inc = (head == nst_pkg::SLOT_W'(nst_pkg::HELD_DEPTH - 1)) ? '0 : head + 1'b1;
    base  = nst_pkg::ADDR_W'(pitch) * nst_pkg::ADDR_W'(nst_pkg::HELD_DEPTH);
    waddr = base + nst_pkg::ADDR_W'(slot);
    raddr = base + nst_pkg::ADDR_W'(head);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.push) begin
      vld_r[pitch] <= 1'b1;
    end
  end

  // Head/count memory, read every cycle at the current pitch
  always_ff @(posedge clk) begin
    head_rd_r <= head_mem[pitch];
    cnt_rd_r  <= cnt_mem[pitch];
    vld_rd_r  <= vld_r[pitch];
    if (cmd.push) begin
      head_mem[pitch] <= head;
      cnt_mem[pitch]  <= count + 1'b1;
    end else if (cmd.pop) begin
      head_mem[pitch] <= head_inc;
      cnt_mem[pitch]  <= count - 1'b1;
    end
  end

  // Delay store
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      dly_mem[waddr] <= cmd.delay;
    end
    if (cmd.pop) begin
      pop_rd_r <= dly_mem[raddr];
    end
  end

  assign pop_delay = pop_rd_r;

endmodule

`default_nettype wire

@@ rtl/note_swing_timing.sv @@
`default_nettype none

// Channel  Dir  Handshake        Payload
// in_ch    in   valid/ready      mode, event_time, pitch, held
// out_ch   out  valid/ready      out_mode, out_time, out_pitch, fifo_dropped
// cfg_*    in   APB write/read   0x0 grid_ticks, 0x4 swing_amount
//
// One item at a time: from accept the item passes the 40-step bit-serial
// divide of event_time by grid_ticks, then S_EVAL, S_CHK, S_FIFO and S_ADD;
// the next item is taken the cycle after the result is registered.
// The result register holds while out_ch.ready is low; the current item
// waits in S_ADD for the register to free, and no new item is accepted meanwhile.
// Synchronous active-low reset; held-note FIFOs come up empty.
module note_swing_timing (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  nst_in_if.sink                                  in_ch,
  nst_out_if.source                               out_ch,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [nst_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [nst_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic      [nst_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                    cfg_pready
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_EVAL = 6'b000100,
    S_CHK  = 6'b001000,
    S_FIFO = 6'b010000,
    S_ADD  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [nst_pkg::GRID_W-1:0]  grid_r;
  logic [nst_pkg::AMT_W-1:0]   amt_r, amt_sat;
  logic [nst_pkg::PROD_W-1:0]  prod;

  nst_pkg::mode_t              mode_r;
  logic [nst_pkg::TIME_W-1:0]  time_r;
  logic [nst_pkg::PITCH_W-1:0] pitch_r;
  logic                        held_r;

  logic [nst_pkg::GRID_W-1:0]  dist_r, dist_nxt;
  logic                        near_odd_r, near_odd_nxt;
  logic [nst_pkg::DELAY_W-1:0] delay_r, delay_nxt;
  logic                        dropped_r, pop_r;

  logic                        out_valid_r;
  nst_pkg::mode_t              out_mode_r;
  logic [nst_pkg::TIME_W-1:0]  out_time_r;
  logic [nst_pkg::PITCH_W-1:0] out_pitch_r;
  logic                        out_drop_r;

  logic                        accept, cfg_wr, out_free, has_fifo, half, on_grid, zero_cfg;
  logic [nst_pkg::GRID_W-1:0]  rem;
  logic                        q_odd, div_done;
  logic [nst_pkg::DELAY_W-1:0] swing_dly, pop_delay, add_val;
  logic [nst_pkg::GRID_W+4:0]  dist20;
  logic [nst_pkg::TIME_W:0]    sum;
  nst_pkg::fifo_cmd_t          fcmd;
  nst_pkg::fifo_stat_t         fstat;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = state_r == S_IDLE;
  assign out_free = !out_valid_r || out_ch.ready;
  assign has_fifo = {1'b0, pitch_r} < (nst_pkg::PITCH_W+1)'(nst_pkg::PITCH_COUNT);

  // Configuration port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[2])
      nst_pkg::REG_GRID:  cfg_prdata = nst_pkg::CFG_DATA_W'(grid_r);
      nst_pkg::REG_SWING: cfg_prdata = nst_pkg::CFG_DATA_W'(amt_r);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= nst_pkg::GRID_RESET;
      amt_r  <= nst_pkg::SWING_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        nst_pkg::REG_GRID:  grid_r <= cfg_pwdata[nst_pkg::GRID_W-1:0];
        nst_pkg::REG_SWING: amt_r  <= cfg_pwdata[nst_pkg::AMT_W-1:0];
        default: ;
      endcase
    end
  end

  // amount * grid, registered in the divide-by-3 shift register
  assign amt_sat = (amt_r > nst_pkg::AMT_W'(nst_pkg::AMT_FULL)) ?
                   nst_pkg::AMT_W'(nst_pkg::AMT_FULL) : amt_r;
  assign prod    = nst_pkg::PROD_W'(amt_sat) * nst_pkg::PROD_W'(grid_r);

  nst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (in_ch.event_time),
    .divisor  (grid_r),
    .rem      (rem),
    .q_odd    (q_odd),
    .done     (div_done)
  );

  nst_div3 u_div3 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .value (prod[nst_pkg::FRAC_SHIFT +: nst_pkg::GRID_W]),
    .quo   (swing_dly)
  );

  nst_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .pitch     (pitch_r[nst_pkg::PIDX_W-1:0]),
    .cmd       (fcmd),
    .stat      (fstat),
    .pop_delay (pop_delay)
  );

  // Nearest division and distance (round half up)
  always_comb begin
    half         = {rem, 1'b0} >= {1'b0, grid_r};
    dist_nxt     = half ? grid_r - rem : rem;
    near_odd_nxt = half ? !q_odd : q_odd;
  end

  // On-grid test and swing delay
  always_comb begin
    dist20    = {1'b0, dist_r, 4'b0000} + {3'b000, dist_r, 2'b00};
    on_grid   = dist20 <= (nst_pkg::GRID_W+5)'(grid_r);
    zero_cfg  = (grid_r == '0) || (amt_r == '0);
    delay_nxt = (on_grid && near_odd_r && !zero_cfg) ? swing_dly : '0;
  end

  // FIFO push for held note-on, pop for note-off
  always_comb begin
    fcmd.push  = (state_r == S_FIFO) && (mode_r == nst_pkg::MODE_ON) && held_r &&
                 has_fifo && !fstat.full;
    fcmd.pop   = (state_r == S_FIFO) && (mode_r == nst_pkg::MODE_OFF) &&
                 has_fifo && !fstat.empty;
    fcmd.delay = delay_r;
  end

  // Saturating time add
  always_comb begin
    if (mode_r == nst_pkg::MODE_ON) begin
      add_val = delay_r;
    end else if (pop_r) begin
      add_val = pop_delay;
    end else begin
      add_val = '0;
    end
    sum = {1'b0, time_r} + (nst_pkg::TIME_W+1)'(add_val);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_CHK;
      S_CHK:  state_nxt = S_FIFO;
      S_FIFO: state_nxt = S_ADD;
      S_ADD:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_ADD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_ch.mode;
      time_r  <= in_ch.event_time;
      pitch_r <= in_ch.pitch;
      held_r  <= in_ch.held;
    end
    if (state_r == S_EVAL) begin
      dist_r     <= dist_nxt;
      near_odd_r <= near_odd_nxt;
    end
    if (state_r == S_CHK) begin
      delay_r <= delay_nxt;
    end
    if (state_r == S_FIFO) begin
      dropped_r <= (mode_r == nst_pkg::MODE_ON) && held_r && (!has_fifo || fstat.full);
      pop_r     <= fcmd.pop;
    end
    if ((state_r == S_ADD) && out_free) begin
      out_mode_r  <= mode_r;
      out_pitch_r <= pitch_r;
      out_drop_r  <= dropped_r;
      out_time_r  <= sum[nst_pkg::TIME_W] ? '1 : sum[nst_pkg::TIME_W-1:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_mode     = out_mode_r;
  assign out_ch.out_time     = out_time_r;
  assign out_ch.out_pitch    = out_pitch_r;
  assign out_ch.fifo_dropped = out_drop_r;

endmodule

`default_nettype wire
